// File: rtl/m2ms_pkg.sv
// Shared types, constants and elaboration-time helpers for the measurement to
// motion state converter. No dependencies.
`default_nettype none

package m2ms_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 30;
    localparam int DATA_W            = 32;
    localparam int XY_W              = 44;  // holds 2^31 << 8 times the vectoring growth
    localparam int Z_W               = 35;  // Q30 radians, pi plus the atan sum
    localparam int VEC_GUARD         = 8;
    localparam int GAIN_W            = 31;
    localparam int WIDE_W            = 80;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    localparam logic [1:0] KIND_POS   = 2'd0;
    localparam logic [1:0] KIND_POLAR = 2'd1;
    localparam logic [1:0] KIND_STATE = 2'd2;
    localparam logic [1:0] KIND_TRUTH = 2'd3;

    typedef logic signed [DATA_W-1:0] word_t;

    // item fields that ride along the pipeline
    typedef struct packed {
        logic [1:0] kind;
        word_t      v0;
        word_t      v1;
        word_t      v2;
        word_t      v3;
        word_t      v4;
        logic       neg;   // rotation result needs negating
        logic       zero;  // truth vector with zero velocity
    } side_t;

    typedef struct packed {
        logic                   rot;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t speed;
        word_t heading;
        word_t turn_rate;
        word_t vel_x;
        word_t vel_y;
    } result_t;

    function automatic int stages_used(input int n);
        return (n > MAX_STAGES) ? MAX_STAGES : n;
    endfunction

    // pi rounded to the given number of fraction bits
    function automatic logic [63:0] pi_at(input int frac);
        return (PI_Q62 + (64'd1 << (61 - frac))) >> (62 - frac);
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] p_in);
        logic [63:0] p;
        logic [63:0] res;
        logic [63:0] b;
        p   = p_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > p)
            b = b >> 2;
        while (b != 64'd0) begin
            if (p >= res + b) begin
                p   = p - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // square root of the Q62 product of the stage gains
    function automatic logic [63:0] gain_root(input int n);
        logic [63:0] p;
        logic [63:0] s;
        p = 64'd1 << 62;
        for (int i = 0; i < stages_used(n); i++)
            p = p + (p >> (2 * i));
        s = isqrt64(p);
        if (s == 64'd0)
            s = 64'd1;
        return s;
    endfunction

    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:  a = Z_W'(843314857);
            1:  a = Z_W'(497837829);
            2:  a = Z_W'(263043837);
            3:  a = Z_W'(133525159);
            4:  a = Z_W'(67021687);
            5:  a = Z_W'(33543516);
            6:  a = Z_W'(16775851);
            7:  a = Z_W'(8388437);
            8:  a = Z_W'(4194283);
            9:  a = Z_W'(2097149);
            default: a = Z_W'(64'd1 << (30 - i));
        endcase
        return a;
    endfunction

    function automatic word_t sat32(input logic signed [WIDE_W-1:0] v);
        word_t r;
        if (v > $signed(WIDE_W'(64'h7FFFFFFF)))
            r = 32'sh7FFFFFFF;
        else if (v < -$signed(WIDE_W'(64'h80000000)))
            r = 32'sh80000000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/m2ms_meas_if.sv
// Input channel: sensor kind and five Q16.16 measurement values.
// No dependencies.
`default_nettype none

interface m2ms_meas_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  sensor_kind;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic signed [31:0] value_4;

    modport source (output valid, sensor_kind, value_0, value_1, value_2, value_3, value_4,
                    input ready);
    modport sink (input valid, sensor_kind, value_0, value_1, value_2, value_3, value_4,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/m2ms_motion_if.sv
// Output channel: motion state and Cartesian vector, Q16.16.
// No dependencies.
`default_nettype none

interface m2ms_motion_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] speed;
    logic signed [31:0] heading;
    logic signed [31:0] turn_rate;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;

    modport source (output valid, pos_x, pos_y, speed, heading, turn_rate, vel_x, vel_y,
                    input ready);
    modport sink (input valid, pos_x, pos_y, speed, heading, turn_rate, vel_x, vel_y,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/m2ms_reduce.sv
// Front end: angle reduction into [-pi/2, pi/2] and CORDIC start values.
// Depends on m2ms_pkg.
`default_nettype none

module m2ms_reduce #(
    parameter int FRAC_BITS     = m2ms_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = m2ms_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire m2ms_pkg::side_t   in_side,
    output logic                   out_valid,
    output m2ms_pkg::cordic_t      out_data,
    output m2ms_pkg::side_t        out_side
);

    localparam int XY_W   = m2ms_pkg::XY_W;
    localparam int Z_W    = m2ms_pkg::Z_W;
    localparam int ANG_SH = 30 - FRAC_BITS;
    localparam int R_W    = ANG_SH;
    localparam int Q_W    = ANG_SH;
    localparam int PROD_W = 32 + R_W;
    localparam int QT_W   = Q_W + 33;

    localparam logic [63:0] TWO_PI64 = m2ms_pkg::pi_at(31);
    localparam logic [63:0] PI64     = m2ms_pkg::pi_at(30);
    localparam logic [63:0] HALF64   = m2ms_pkg::pi_at(29);
    localparam logic [63:0] RECIP64  = (64'd1 << (ANG_SH + 32)) / TWO_PI64;
    localparam logic [63:0] ROOT64   = m2ms_pkg::gain_root(CORDIC_STAGES);
    localparam logic [63:0] GAIN64   = ((64'd1 << 61) + (ROOT64 >> 1)) / ROOT64;

    localparam logic [R_W-1:0]        RECIP     = RECIP64[R_W-1:0];
    localparam logic [32:0]           TWO_PI    = TWO_PI64[32:0];
    localparam logic signed [Z_W-1:0] TWO_PI_Z  = $signed(Z_W'(TWO_PI64));
    localparam logic signed [Z_W-1:0] PI_Z      = $signed(Z_W'(PI64));
    localparam logic signed [Z_W-1:0] HALF_Z    = $signed(Z_W'(HALF64));
    localparam logic signed [XY_W-1:0] GAIN_XY  = $signed(XY_W'(GAIN64));

    logic                  s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    m2ms_pkg::side_t       s0_side_reg, s1_side_reg, s2_side_reg, s3_side_reg;
    logic [31:0]           s0_abs_reg, s1_abs_reg, s2_abs_reg;
    logic                  s0_sgn_reg, s1_sgn_reg, s2_sgn_reg, s3_sgn_reg;
    logic [PROD_W-1:0]     s1_prod_reg;
    logic [QT_W-1:0]       s2_qt_reg;
    logic [32:0]           s3_rem_reg;
    logic                  out_valid_reg;
    m2ms_pkg::cordic_t     out_data_reg;
    m2ms_pkg::side_t       out_side_reg;

    m2ms_pkg::word_t       ang;
    logic [31:0]           abs_next;
    logic [PROD_W-1:0]     prod_next;
    logic [Q_W-1:0]        quot;
    logic [QT_W-1:0]       qt_next;
    logic [QT_W-1:0]       rem;
    logic [QT_W-1:0]       rem_c;
    logic signed [Z_W-1:0] remz, zz, zs, zr;
    logic                  half_neg;
    logic signed [XY_W-1:0] vx, vy;
    logic signed [Z_W-1:0] zv;
    m2ms_pkg::cordic_t     data_next;
    m2ms_pkg::side_t       side_next;

    always_comb
    begin
        ang      = (in_side.kind == m2ms_pkg::KIND_POLAR) ? in_side.v1 : in_side.v3;
        abs_next = ang[31] ? 32'(-ang) : 32'(ang);
        prod_next = s0_abs_reg * RECIP;
        quot      = s1_prod_reg[PROD_W-1 -: Q_W];
        qt_next   = quot * TWO_PI;
        // quotient estimate is at most one low
        rem   = QT_W'({s2_abs_reg, {ANG_SH{1'b0}}}) - s2_qt_reg;
        rem_c = (rem >= QT_W'(TWO_PI)) ? rem - QT_W'(TWO_PI) : rem;
    end

    always_comb
    begin
        remz = $signed(Z_W'(s3_rem_reg));
        zz   = (remz > PI_Z) ? remz - TWO_PI_Z : remz;
        zs   = s3_sgn_reg ? -zz : zz;
        half_neg = 1'b0;
        zr       = zs;
        if (zs > HALF_Z) begin
            zr       = zs - PI_Z;
            half_neg = 1'b1;
        end else if (zs < -HALF_Z) begin
            zr       = zs + PI_Z;
            half_neg = 1'b1;
        end

        vx = $signed({{(XY_W-40){s3_side_reg.v2[31]}}, s3_side_reg.v2, 8'b0});
        vy = $signed({{(XY_W-40){s3_side_reg.v3[31]}}, s3_side_reg.v3, 8'b0});
        zv = '0;
        if (s3_side_reg.v2[31]) begin
            zv = s3_side_reg.v3[31] ? -PI_Z : PI_Z;
            vx = -vx;
            vy = -vy;
        end

        data_next.rot = (s3_side_reg.kind != m2ms_pkg::KIND_TRUTH);
        data_next.x   = data_next.rot ? GAIN_XY : vx;
        data_next.y   = data_next.rot ? '0 : vy;
        data_next.z   = data_next.rot ? zr : zv;

        side_next      = s3_side_reg;
        side_next.neg  = data_next.rot & half_neg;
        side_next.zero = (s3_side_reg.v2 == '0) && (s3_side_reg.v3 == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg  <= in_valid;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s0_side_reg  <= in_side;
            s0_abs_reg   <= abs_next;
            s0_sgn_reg   <= ang[31];
            s1_side_reg  <= s0_side_reg;
            s1_abs_reg   <= s0_abs_reg;
            s1_sgn_reg   <= s0_sgn_reg;
            s1_prod_reg  <= prod_next;
            s2_side_reg  <= s1_side_reg;
            s2_abs_reg   <= s1_abs_reg;
            s2_sgn_reg   <= s1_sgn_reg;
            s2_qt_reg    <= qt_next;
            s3_side_reg  <= s2_side_reg;
            s3_sgn_reg   <= s2_sgn_reg;
            s3_rem_reg   <= rem_c[32:0];
            out_data_reg <= data_next;
            out_side_reg <= side_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_side  = out_side_reg;

endmodule

`default_nettype wire

// File: rtl/m2ms_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode per item.
// Depends on m2ms_pkg.
`default_nettype none

module m2ms_cell #(
    parameter int STAGE = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire m2ms_pkg::cordic_t in_data,
    input  wire m2ms_pkg::side_t   in_side,
    output logic                   out_valid,
    output m2ms_pkg::cordic_t      out_data,
    output m2ms_pkg::side_t        out_side
);

    localparam int XY_W = m2ms_pkg::XY_W;
    localparam logic signed [m2ms_pkg::Z_W-1:0] ATAN = m2ms_pkg::atan_q30(STAGE);

    logic                   valid_reg;
    m2ms_pkg::cordic_t      data_reg;
    m2ms_pkg::side_t        side_reg;
    logic signed [XY_W-1:0] xs, ys;
    logic                   ccw;
    m2ms_pkg::cordic_t      data_next;

    always_comb
    begin
        xs  = $signed(in_data.x) >>> STAGE;
        ys  = $signed(in_data.y) >>> STAGE;
        // rotation follows the residual angle, vectoring drives y to zero
        ccw = in_data.rot ? !in_data.z[m2ms_pkg::Z_W-1] : in_data.y[XY_W-1];
        data_next.rot = in_data.rot;
        data_next.x   = ccw ? in_data.x - ys : in_data.x + ys;
        data_next.y   = ccw ? in_data.y + xs : in_data.y - xs;
        data_next.z   = ccw ? in_data.z - ATAN : in_data.z + ATAN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/m2ms_post.sv
// Back end: scaling products, gain correction, rounding, saturation and
// result assembly per sensor kind. Depends on m2ms_pkg.
`default_nettype none

module m2ms_post #(
    parameter int FRAC_BITS     = m2ms_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = m2ms_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire m2ms_pkg::cordic_t in_data,
    input  wire m2ms_pkg::side_t   in_side,
    output logic                   out_valid,
    output m2ms_pkg::result_t      out_item
);

    localparam int XY_W   = m2ms_pkg::XY_W;
    localparam int Z_W    = m2ms_pkg::Z_W;
    localparam int WIDE_W = m2ms_pkg::WIDE_W;
    localparam int GAIN_W = m2ms_pkg::GAIN_W;
    localparam int LO_W   = 24 + GAIN_W;
    localparam int HI_W   = XY_W - 25 + GAIN_W;
    localparam int H_SH   = 30 - FRAC_BITS;

    localparam logic [63:0] ROOT64 = m2ms_pkg::gain_root(CORDIC_STAGES);
    localparam logic [63:0] GAIN64 = ((64'd1 << 61) + (ROOT64 >> 1)) / ROOT64;
    localparam logic [GAIN_W-1:0] GAIN = GAIN64[GAIN_W-1:0];
    localparam logic signed [WIDE_W-1:0] PIF      = $signed(WIDE_W'(m2ms_pkg::pi_at(FRAC_BITS)));
    localparam logic signed [WIDE_W-1:0] P_ROUND  = $signed(WIDE_W'(64'd1 << 29));
    localparam logic signed [WIDE_W-1:0] H_ROUND  = $signed(WIDE_W'(64'd1 << (29 - FRAC_BITS)));
    localparam logic [WIDE_W-1:0]        S_ROUND  = WIDE_W'(64'd1 << (29 + m2ms_pkg::VEC_GUARD));
    localparam logic [WIDE_W-1:0]        S_MAX    = WIDE_W'(64'h7FFFFFFF);

    logic                   m_valid_reg;
    m2ms_pkg::side_t        m_side_reg;
    logic signed [64:0]     m_pc_reg, m_ps_reg;
    logic [LO_W-1:0]        m_lo_reg;
    logic [HI_W-1:0]        m_hi_reg;
    logic signed [Z_W-1:0]  m_z_reg;
    logic                   f_valid_reg;
    m2ms_pkg::result_t      f_item_reg;

    m2ms_pkg::word_t        mag;
    logic signed [64:0]     pc_next, ps_next;
    logic [XY_W-2:0]        xv;
    logic [LO_W-1:0]        lo_next;
    logic [HI_W-1:0]        hi_next;

    logic signed [WIDE_W-1:0] pcn, psn, hz;
    logic [WIDE_W-1:0]        ssum, sshift;
    m2ms_pkg::word_t          rc, rs, spd, hdg;
    m2ms_pkg::result_t        item_next;

    always_comb
    begin
        mag     = (in_side.kind == m2ms_pkg::KIND_POLAR) ? in_side.v0 : in_side.v2;
        pc_next = mag * $signed(in_data.x[32:0]);
        ps_next = mag * $signed(in_data.y[32:0]);
        xv      = in_data.x[XY_W-1] ? '0 : in_data.x[XY_W-2:0];
        lo_next = xv[23:0] * GAIN;
        hi_next = xv[XY_W-2:24] * GAIN;
    end

    always_comb
    begin
        pcn = m_side_reg.neg ? -WIDE_W'(m_pc_reg) : WIDE_W'(m_pc_reg);
        psn = m_side_reg.neg ? -WIDE_W'(m_ps_reg) : WIDE_W'(m_ps_reg);
        rc  = m2ms_pkg::sat32((pcn + P_ROUND) >>> 30);
        rs  = m2ms_pkg::sat32((psn + P_ROUND) >>> 30);

        ssum   = {m_hi_reg, 24'b0} + WIDE_W'(m_lo_reg) + S_ROUND;
        sshift = ssum >> (30 + m2ms_pkg::VEC_GUARD);
        spd    = (sshift > S_MAX) ? 32'sh7FFFFFFF : sshift[31:0];

        hz = (WIDE_W'(m_z_reg) + H_ROUND) >>> H_SH;
        if (hz > PIF)
            hz = PIF;
        else if (hz < -PIF)
            hz = -PIF;
        hdg = hz[31:0];

        item_next = '0;
        item_next.pos_x = m_side_reg.v0;
        item_next.pos_y = m_side_reg.v1;
        case (m_side_reg.kind)
            m2ms_pkg::KIND_POLAR:
            begin
                item_next.pos_x = rc;
                item_next.pos_y = rs;
            end
            m2ms_pkg::KIND_STATE:
            begin
                item_next.speed     = m_side_reg.v2;
                item_next.heading   = m_side_reg.v3;
                item_next.turn_rate = m_side_reg.v4;
                item_next.vel_x     = rc;
                item_next.vel_y     = rs;
            end
            m2ms_pkg::KIND_TRUTH:
            begin
                item_next.speed   = m_side_reg.zero ? '0 : spd;
                item_next.heading = m_side_reg.zero ? '0 : hdg;
                item_next.vel_x   = m_side_reg.v2;
                item_next.vel_y   = m_side_reg.v3;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= in_valid;
            f_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            m_side_reg <= in_side;
            m_pc_reg   <= pc_next;
            m_ps_reg   <= ps_next;
            m_lo_reg   <= lo_next;
            m_hi_reg   <= hi_next;
            m_z_reg    <= in_data.z;
            f_item_reg <= item_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_item  = f_item_reg;

endmodule

`default_nettype wire

// File: rtl/measurement_to_motion_state.sv
// Top level: reduction front end, chain of CORDIC cells, back end, output skid.
// Depends on m2ms_pkg, m2ms_meas_if, m2ms_motion_if, m2ms_reduce, m2ms_cell, m2ms_post.
//
// Converts one sensor measurement per item into the motion state and the
// Cartesian vector. One item is accepted every clock while ready is high;
// each item passes through the angle reduction and start-value registers,
// the chain of CORDIC cells, the product and rounding registers and the
// output register. A two-entry output buffer lets the pipeline keep taking
// items after the sink stalls; ready drops only once that buffer holds a
// waiting result. No configuration, no state across items.
`default_nettype none

module measurement_to_motion_state #(
    parameter int FRAC_BITS     = m2ms_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = m2ms_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    m2ms_meas_if.sink      meas,
    m2ms_motion_if.source  motion
);

    localparam int STAGES = m2ms_pkg::stages_used(CORDIC_STAGES);

    logic                en;
    m2ms_pkg::side_t     in_side;
    logic                chain_valid [0:STAGES];
    m2ms_pkg::cordic_t   chain_data  [0:STAGES];
    m2ms_pkg::side_t     chain_side  [0:STAGES];
    logic                last_valid;
    m2ms_pkg::result_t   last_item;

    logic                out_valid_reg, skid_valid_reg;
    m2ms_pkg::result_t   out_reg, skid_reg;

    assign en         = !skid_valid_reg;
    assign meas.ready = en;

    always_comb
    begin
        in_side      = '0;
        in_side.kind = meas.sensor_kind;
        in_side.v0   = meas.value_0;
        in_side.v1   = meas.value_1;
        in_side.v2   = meas.value_2;
        in_side.v3   = meas.value_3;
        in_side.v4   = meas.value_4;
    end

    m2ms_reduce #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (meas.valid),
        .in_side   (in_side),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0]),
        .out_side  (chain_side[0])
    );

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        m2ms_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .in_side   (chain_side[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1]),
            .out_side  (chain_side[g+1])
        );
    end

    m2ms_post #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[STAGES]),
        .in_data   (chain_data[STAGES]),
        .in_side   (chain_side[STAGES]),
        .out_valid (last_valid),
        .out_item  (last_item)
    );

    // output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || motion.ready) begin
            out_valid_reg  <= skid_valid_reg | last_valid;
            skid_valid_reg <= 1'b0;
        end else if (en && last_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || motion.ready)
            out_reg <= skid_valid_reg ? skid_reg : last_item;
        else if (en && last_valid)
            skid_reg <= last_item;
    end

    assign motion.valid     = out_valid_reg;
    assign motion.pos_x     = out_reg.pos_x;
    assign motion.pos_y     = out_reg.pos_y;
    assign motion.speed     = out_reg.speed;
    assign motion.heading   = out_reg.heading;
    assign motion.turn_rate = out_reg.turn_rate;
    assign motion.vel_x     = out_reg.vel_x;
    assign motion.vel_y     = out_reg.vel_y;

endmodule

`default_nettype wire

// File: verif/m2ms_checker.sv
// Checker for measurement_to_motion_state: watches both channels, predicts
// each result with a fixed-point CORDIC model and compares. Uses m2ms_pkg.
`timescale 1ns / 100ps

module m2ms_checker #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    m2ms_meas_if.sink    meas_mon,
    m2ms_motion_if.sink  motion_mon,
    output int           fail_count,
    output int           pending
);

    localparam int NST = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

    m2ms_pkg::result_t motion_q[$];

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint pi_q(int frac);
        longint unsigned p;
        p = 64'hC90FDAA22168C235;
        return longint'((p + (64'd1 << (61 - frac))) >> (62 - frac));
    endfunction

    function automatic longint atan_tab(int i);
        longint t [10];
        t = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
              16775851, 8388437, 4194283, 2097149};
        return (i < 10) ? t[i] : (longint'(1) << (30 - i));
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint root64(longint unsigned p);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > p)
            b = b >> 2;
        while (b != 0) begin
            if (p >= r + b) begin
                p = p - (r + b);
                r = (r >> 1) + b;
            end else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint cordic_gain();
        longint unsigned p, s;
        p = 64'd1 << 62;
        for (int i = 0; i < NST; i++)
            p = p + (p >> (2 * i));
        s = root64(p);
        if (s == 0)
            s = 1;
        return longint'(((64'd1 << 61) + (s >> 1)) / s);
    endfunction

    function automatic void rotate(input longint ang, input longint k, output longint c,
                                   output longint s);
        longint z, x, y, nx, tp, pi, hp;
        bit flip;
        tp = pi_q(31);
        pi = pi_q(30);
        hp = pi_q(29);
        z = ang * (longint'(1) << (30 - FRAC_BITS));
        x = k;
        y = 0;
        flip = 0;
        z = z % tp;
        if (z > pi) z -= tp;
        if (z < -pi) z += tp;
        if (z > hp) begin
            z -= pi;
            flip = 1;
        end else if (z < -hp) begin
            z += pi;
            flip = 1;
        end
        for (int i = 0; i < NST; i++) begin
            if (z >= 0) begin
                nx = x - shr(y, i); y = y + shr(x, i); z -= atan_tab(i);
            end else begin
                nx = x + shr(y, i); y = y - shr(x, i); z += atan_tab(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint scale30(longint v, longint f);
        return clamp32(shr(v * f + (longint'(1) << 29), 30));
    endfunction

    function automatic void to_polar(input longint vx, input longint vy, input longint k,
                                     output longint spd, output longint hdg);
        longint x, y, z, nx, pif;
        logic [127:0] prod;
        pif = pi_q(FRAC_BITS);
        if (vx == 0 && vy == 0) begin
            spd = 0;
            hdg = 0;
            return;
        end
        x = vx <<< m2ms_pkg::VEC_GUARD;
        y = vy <<< m2ms_pkg::VEC_GUARD;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? pi_q(30) : -pi_q(30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < NST; i++) begin
            if (y >= 0) begin
                nx = x + shr(y, i); y = y - shr(x, i); z += atan_tab(i);
            end else begin
                nx = x - shr(y, i); y = y + shr(x, i); z -= atan_tab(i);
            end
            x = nx;
        end
        if (x < 0) x = 0;
        prod = (128'(x) * 128'(k) + (128'd1 << (29 + m2ms_pkg::VEC_GUARD)))
               >> (30 + m2ms_pkg::VEC_GUARD);
        spd = (prod > 128'h7FFFFFFF) ? 64'sd2147483647 : longint'(prod);
        z = shr(z + (longint'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS);
        if (z > pif) z = pif;
        if (z < -pif) z = -pif;
        hdg = z;
    endfunction

    function automatic m2ms_pkg::result_t predict_motion(logic [1:0] kind,
        m2ms_pkg::word_t a0, m2ms_pkg::word_t a1, m2ms_pkg::word_t a2,
        m2ms_pkg::word_t a3, m2ms_pkg::word_t a4);
        m2ms_pkg::result_t r;
        longint k, c, s, sp, hd;
        k = cordic_gain();
        r = '0;
        r.pos_x = a0;
        r.pos_y = a1;
        case (kind)
            m2ms_pkg::KIND_POLAR: begin
                rotate(a1, k, c, s);
                r.pos_x = m2ms_pkg::word_t'(scale30(a0, c));
                r.pos_y = m2ms_pkg::word_t'(scale30(a0, s));
            end
            m2ms_pkg::KIND_STATE: begin
                r.speed = a2;
                r.heading = a3;
                r.turn_rate = a4;
                rotate(a3, k, c, s);
                r.vel_x = m2ms_pkg::word_t'(scale30(a2, c));
                r.vel_y = m2ms_pkg::word_t'(scale30(a2, s));
            end
            m2ms_pkg::KIND_TRUTH: begin
                to_polar(a2, a3, k, sp, hd);
                r.speed = m2ms_pkg::word_t'(sp);
                r.heading = m2ms_pkg::word_t'(hd);
                r.vel_x = a2;
                r.vel_y = a3;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic cmp(string name, m2ms_pkg::word_t e, m2ms_pkg::word_t a);
        if (e !== a) begin
            $error("%s: expected %0d actual %0d", name, e, a);
            fail_count++;
        end
    endtask

    assign pending = motion_q.size();

    initial fail_count = 0;

    always @(posedge clk) begin
        m2ms_pkg::result_t e;
        if (rst_n && meas_mon.valid && meas_mon.ready)
            motion_q.push_back(predict_motion(meas_mon.sensor_kind, meas_mon.value_0,
                meas_mon.value_1, meas_mon.value_2, meas_mon.value_3, meas_mon.value_4));
        if (rst_n && motion_mon.valid && motion_mon.ready) begin
            if (motion_q.size() == 0) begin
                $error("result item with no expectation");
                fail_count++;
            end else begin
                e = motion_q.pop_front();
                cmp("pos_x", e.pos_x, motion_mon.pos_x);
                cmp("pos_y", e.pos_y, motion_mon.pos_y);
                cmp("speed", e.speed, motion_mon.speed);
                cmp("heading", e.heading, motion_mon.heading);
                cmp("turn_rate", e.turn_rate, motion_mon.turn_rate);
                cmp("vel_x", e.vel_x, motion_mon.vel_x);
                cmp("vel_y", e.vel_y, motion_mon.vel_y);
            end
        end
    end
endmodule

// File: verif/tb.sv
// Testbench top for measurement_to_motion_state: clock, reset, stimulus,
// idling and verdict. Depends on m2ms_pkg, the channel interfaces, m2ms_checker.
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY = 16 + 8;
    localparam int N_RANDOM = 1500;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 0;
    logic rst_n = 0;
    int   cycles = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   fail_count;
    int   pending;

    m2ms_meas_if   meas ();
    m2ms_motion_if motion ();

    measurement_to_motion_state dut (.clk(clk), .rst_n(rst_n), .meas(meas), .motion(motion));

    m2ms_checker chk (.clk(clk), .rst_n(rst_n), .meas_mon(meas), .motion_mon(motion),
                      .fail_count(fail_count), .pending(pending));

    always #5 clk = ~clk;

    initial begin
        meas.valid = 0;
        meas.sensor_kind = m2ms_pkg::KIND_POS;
        meas.value_0 = 0;
        meas.value_1 = 0;
        meas.value_2 = 0;
        meas.value_3 = 0;
        meas.value_4 = 0;
        motion.ready = 0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
        if (rst_n)
            motion.ready <= ($urandom_range(99) >= recv_idle);

    function automatic m2ms_pkg::word_t rand_word();
        case ($urandom_range(7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 0;
            3, 4: return m2ms_pkg::word_t'($urandom);
            default: return m2ms_pkg::word_t'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    task automatic send_item(logic [1:0] kind, m2ms_pkg::word_t a0, m2ms_pkg::word_t a1,
                             m2ms_pkg::word_t a2, m2ms_pkg::word_t a3, m2ms_pkg::word_t a4);
        while ($urandom_range(99) < send_idle) begin
            meas.valid <= 0;
            @(posedge clk);
        end
        meas.valid <= 1;
        meas.sensor_kind <= kind;
        meas.value_0 <= a0;
        meas.value_1 <= a1;
        meas.value_2 <= a2;
        meas.value_3 <= a3;
        meas.value_4 <= a4;
        @(posedge clk);
        while (!meas.ready)
            @(posedge clk);
    endtask

    initial begin
        logic [1:0] kind;
        m2ms_pkg::word_t pi16;
        pi16 = m2ms_pkg::word_t'(m2ms_pkg::pi_at(16));
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_idle = 30;
        recv_idle = 47;
        // directed: extremes, each kind, zero velocity, angles near the quadrant edges
        for (int k = 0; k < 4; k++) begin
            send_item(k[1:0], 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                      32'sh80000000, 32'sh7FFFFFFF);
            send_item(k[1:0], 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                      32'sh7FFFFFFF, 32'sh80000000);
            send_item(k[1:0], 0, 0, 0, 0, 0);
        end
        send_item(m2ms_pkg::KIND_POLAR, 1 << 16, pi16, 0, 0, 0);
        send_item(m2ms_pkg::KIND_POLAR, 1 << 16, -pi16, 0, 0, 0);
        send_item(m2ms_pkg::KIND_POLAR, 5 << 16, pi16 >>> 1, 0, 0, 0);
        send_item(m2ms_pkg::KIND_POLAR, -(3 << 16), -(pi16 >>> 1) - 1, 0, 0, 0);
        send_item(m2ms_pkg::KIND_STATE, 1, 2, 4 << 16, 7 << 16, 3);
        send_item(m2ms_pkg::KIND_TRUTH, 0, 0, -(1 << 16), 0, 0);
        send_item(m2ms_pkg::KIND_TRUTH, 0, 0, -(1 << 16), -1, 0);
        send_item(m2ms_pkg::KIND_TRUTH, 0, 0, 0, 1 << 16, 0);
        send_item(m2ms_pkg::KIND_TRUTH, 0, 0, 0, -(1 << 16), 0);
        send_item(m2ms_pkg::KIND_TRUTH, 0, 0, 32'sh80000000, 32'sh80000000, 0);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle = 47;
                recv_idle = 30;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            kind = 2'($urandom_range(3));
            send_item(kind, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        end
        meas.valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// File: measurement_to_motion_state.f
rtl/m2ms_pkg.sv
rtl/m2ms_meas_if.sv
rtl/m2ms_motion_if.sv
rtl/m2ms_reduce.sv
rtl/m2ms_cell.sv
rtl/m2ms_post.sv
rtl/measurement_to_motion_state.sv
verif/m2ms_checker.sv
verif/tb.sv
